// ----- src/tdc_pkg.sv -----
// ---------------------------------------------------------------------------
// tdc_pkg
// Shared types, codes and helpers for the two-digit counter with a
// multiplexed BCD display.
// ---------------------------------------------------------------------------
package tdc_pkg;

    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    localparam logic [6:0]  COUNT_MAX    = 7'd99;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam logic [16:0] PERIOD_MAX   = 17'd60000;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_FASTER = 3'd1,
        ACT_SLOWER = 3'd2,
        ACT_STOP   = 3'd3,
        ACT_RESUME = 3'd4,
        ACT_PRESET = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        CFG_SPEED_STEP = 2'd0,
        CFG_MIN_PERIOD = 2'd1,
        CFG_BLANK      = 2'd2,
        CFG_SHOW       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_BLANK_UNITS = 2'd0,
        PH_UNITS       = 2'd1,
        PH_BLANK_TENS  = 2'd2,
        PH_TENS        = 2'd3
    } phase_t;

    typedef struct packed {
        logic [9:0] speed_step_ms;
        logic [9:0] min_period_ms;
        logic [3:0] blank_ms;
        logic [7:0] show_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] preset_value;
    } item_t;

    typedef struct packed {
        logic [3:0] bcd_digit;
        logic       units_enable;
        logic       tens_enable;
        logic [6:0] count_value;
        logic       preset_rejected;
    } result_t;

    // Split a value of 0..99 into {tens, units}; tens by reciprocal multiply.
    function automatic logic [7:0] bcd_split(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        prod     = 15'(value) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'(tens) * 7'd10;
        units    = value - tens_x10;
        return {tens, units[3:0]};
    endfunction

endpackage

// ----- src/tdc_if.sv -----
// ---------------------------------------------------------------------------
// tdc_if
// Valid/ready channels: command requests in, display results out.
// ---------------------------------------------------------------------------
interface tdc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] preset_value;

    modport source (output valid, action, preset_value, input ready);
    modport sink   (input valid, action, preset_value, output ready);
endinterface

interface tdc_disp_if;
    logic       valid;
    logic       ready;
    logic [3:0] bcd_digit;
    logic       units_enable;
    logic       tens_enable;
    logic [6:0] count_value;
    logic       preset_rejected;

    modport source (output valid, bcd_digit, units_enable, tens_enable, count_value,
                    preset_rejected, input ready);
    modport sink   (input valid, bcd_digit, units_enable, tens_enable, count_value,
                    preset_rejected, output ready);
endinterface

// ----- src/tdc_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// tdc_cfg_regs
// Configuration register file written through a plain write port.
// ---------------------------------------------------------------------------
module tdc_cfg_regs
    import tdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_STEP: cfg_next.speed_step_ms = cfg_data;
                CFG_MIN_PERIOD: cfg_next.min_period_ms = cfg_data;
                CFG_BLANK:      cfg_next.blank_ms      = cfg_data[3:0];
                CFG_SHOW:       cfg_next.show_ms       = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_step_ms <= 10'd100;
            cfg_reg.min_period_ms <= 10'd100;
            cfg_reg.blank_ms      <= 4'd1;
            cfg_reg.show_ms       <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/tdc_in_stage.sv -----
// ---------------------------------------------------------------------------
// tdc_in_stage
// Input register: captures one request and holds it until the core takes it.
// ---------------------------------------------------------------------------
module tdc_in_stage
    import tdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tdc_cmd_if.sink      cmd,
    input  logic         take,
    output logic         item_valid,
    output item_t        item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held request moves on this cycle.
    assign cmd.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.ready)
        begin
            valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.action       <= cmd.action;
            item_reg.preset_value <= cmd.preset_value;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/tdc_core.sv -----
// ---------------------------------------------------------------------------
// tdc_core
// Counter, period, stop flag and display multiplexer state, with the
// result register that presents the state after each request.
// ---------------------------------------------------------------------------
module tdc_core
    import tdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         item_valid,
    input  item_t        item,
    output logic         take,
    tdc_disp_if.source   disp
);

    logic [6:0]  count_reg,   count_next;
    logic [15:0] period_reg,  period_next;
    logic [15:0] acc_reg,     acc_next;
    logic        stopped_reg, stopped_next;
    phase_t      phase_reg,   phase_next;
    logic [7:0]  timer_reg,   timer_next;
    logic [6:0]  snap_reg,    snap_next;
    logic        out_valid_reg;
    result_t     res_reg,     res_next;

    logic [15:0] acc_inc;
    logic [7:0]  timer_inc;
    logic [7:0]  phase_len;
    phase_t      phase_step;
    logic [16:0] slower_sum;
    logic [15:0] step_ext;
    logic [7:0]  bcd;

    assign take = item_valid && (!out_valid_reg || disp.ready);

    assign acc_inc    = acc_reg + 16'd1;
    assign timer_inc  = timer_reg + 8'd1;
    assign step_ext   = 16'(cfg.speed_step_ms);
    assign slower_sum = {1'b0, period_reg} + 17'(cfg.speed_step_ms);
    assign phase_step = phase_t'(phase_reg + 2'd1);

    // Blank phases use blank_ms; digit phases use show_ms, zero read as one.
    always_comb
    begin
        if (!phase_reg[0])
        begin
            phase_len = 8'(cfg.blank_ms);
        end
        else if (cfg.show_ms == 8'd0)
        begin
            phase_len = 8'd1;
        end
        else
        begin
            phase_len = cfg.show_ms;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        period_next  = period_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        snap_next    = snap_reg;
        res_next     = '0;

        case (item.action)
            ACT_TICK:
            begin
                if (acc_inc >= period_reg)
                begin
                    acc_next = 16'd0;
                    if (!stopped_reg)
                    begin
                        count_next = (count_reg >= COUNT_MAX) ? 7'd0 : count_reg + 7'd1;
                    end
                end
                else
                begin
                    acc_next = acc_inc;
                end
                if (timer_inc >= phase_len)
                begin
                    timer_next = 8'd0;
                    phase_next = phase_step;
                    if (phase_step == PH_BLANK_UNITS)
                    begin
                        snap_next = count_next;
                    end
                    // Skip a blank phase of zero length.
                    if (!phase_step[0] && cfg.blank_ms == 4'd0)
                    begin
                        phase_next = phase_t'(phase_step + 2'd1);
                    end
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            ACT_FASTER:
            begin
                if (period_reg > 16'(cfg.min_period_ms))
                begin
                    period_next = (period_reg > step_ext + 16'd1) ?
                                  period_reg - step_ext : 16'd1;
                end
            end
            ACT_SLOWER:
            begin
                period_next = (slower_sum > PERIOD_MAX) ? PERIOD_MAX[15:0] : slower_sum[15:0];
            end
            ACT_STOP:   stopped_next = 1'b1;
            ACT_RESUME: stopped_next = 1'b0;
            ACT_PRESET:
            begin
                if (item.preset_value <= 8'(COUNT_MAX))
                begin
                    count_next = item.preset_value[6:0];
                end
                else
                begin
                    res_next.preset_rejected = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        bcd = bcd_split(snap_next);
        case (phase_next)
            PH_UNITS:
            begin
                res_next.bcd_digit    = bcd[3:0];
                res_next.units_enable = 1'b1;
            end
            PH_TENS:
            begin
                res_next.bcd_digit   = bcd[7:4];
                res_next.tens_enable = 1'b1;
            end
            default:
            begin
                res_next.bcd_digit = 4'd0;
            end
        endcase
        res_next.count_value = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 7'd0;
            period_reg    <= PERIOD_RESET;
            acc_reg       <= 16'd0;
            stopped_reg   <= 1'b0;
            phase_reg     <= PH_BLANK_UNITS;
            timer_reg     <= 8'd0;
            snap_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg   <= count_next;
                period_reg  <= period_next;
                acc_reg     <= acc_next;
                stopped_reg <= stopped_next;
                phase_reg   <= phase_next;
                timer_reg   <= timer_next;
                snap_reg    <= snap_next;
            end
            // Hold the result until taken; refill in the same cycle.
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (disp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign disp.valid           = out_valid_reg;
    assign disp.bcd_digit       = res_reg.bcd_digit;
    assign disp.units_enable    = res_reg.units_enable;
    assign disp.tens_enable     = res_reg.tens_enable;
    assign disp.count_value     = res_reg.count_value;
    assign disp.preset_rejected = res_reg.preset_rejected;

endmodule

// ----- src/two_digit_counter_mux_display_top.sv -----
// ---------------------------------------------------------------------------
// two_digit_counter_mux_display_top
// Mod-100 counter with tick-driven period and a multiplexed BCD display.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   cmd      | in  | valid/ready  | action, preset_value
//   disp     | out | valid/ready  | bcd_digit, units_enable, tens_enable,
//            |     |              | count_value, preset_rejected
//   cfg      | in  | cfg_we only  | cfg_index, cfg_data
//
// One request per cycle sustained while disp.ready stays high; a request's
// result passes through the input register, then the result register,
// before it is presented.
// Reset returns the count, period (1000), accumulator, stop flag and display
// phase to their start values and the config registers to their defaults.
// A stalled result holds in the result register while the input register
// keeps one more request; cmd.ready drops only when both are full.
// ---------------------------------------------------------------------------
module two_digit_counter_mux_display_top
    import tdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    tdc_cmd_if.sink                cmd,
    tdc_disp_if.source             disp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    logic  take;
    logic  item_valid;
    item_t item;

    tdc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tdc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tdc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .disp       (disp)
    );

endmodule
